/* sv/stm_pkg.sv */
// Shared constants, types, font and label tables for the status text marquee.
`default_nettype none

package stm_pkg;

    localparam int PanelColumns = 12;
    localparam int GlyphRows    = 6;
    localparam int GlyphWidth   = 4;
    localparam int GlyphPitch   = 5;
    localparam int RowBits      = 12;
    localparam int LabelChars   = 10;
    localparam int NowBits      = 32;
    localparam int StateBits    = 4;
    localparam int IntervalBits = 16;
    localparam int OffsetBits   = 7;
    localparam int WidthBits    = 6;
    localparam int InBytes      = 5;
    localparam int OutBits      = 8 * RowBits;
    localparam int CfgIndexBits = 2;

    typedef logic [0:LabelChars-1][7:0]            label_t;
    typedef logic [GlyphRows-1:0][RowBits-1:0]     glyph_rows_t;
    typedef logic signed [OffsetBits-1:0]          offset_t;

    localparam logic [CfgIndexBits-1:0] RegDisplayEnabled = 2'd0;
    localparam logic [CfgIndexBits-1:0] RegScrollInterval = 2'd1;
    localparam logic [CfgIndexBits-1:0] RegBlinkInterval  = 2'd2;

    localparam logic [StateBits-1:0]    FaultState    = 4'd10;
    localparam logic [StateBits-1:0]    StateReset    = 4'd15;
    localparam logic [IntervalBits-1:0] ScrollDefault = 16'd90;
    localparam logic [IntervalBits-1:0] BlinkDefault  = 16'd400;
    localparam offset_t                 ScrollStart   = OffsetBits'(-PanelColumns);

    // A through Z, row 0 in the top nibble
    localparam logic [GlyphRows*GlyphWidth-1:0] FontRom [26] = '{
        24'h699F99, 24'hE9E99E, 24'h788887, 24'hE9999E, 24'hF8E88F, 24'hF8E888,
        24'h78B997, 24'h99F999, 24'hE4444E, 24'h7222A4, 24'h9ACCA9, 24'h88888F,
        24'h9FF999, 24'h9DDBB9, 24'h699996, 24'hE99E88, 24'h699BA5, 24'hE99EA9,
        24'h78611E, 24'hF44444, 24'h999996, 24'h999966, 24'h999FF9, 24'h996699,
        24'h996444, 24'hF1248F
    };

    function automatic label_t label_text(input logic [StateBits-1:0] st);
        label_t txt;
        unique case (st)
            4'd1:    txt = "IDLE      ";
            4'd2:    txt = "VALVE OPEN";
            4'd3:    txt = "CHOKE     ";
            4'd4:    txt = "CRANKING  ";
            4'd5:    txt = "UNCHOKE   ";
            4'd6:    txt = "RUNNING   ";
            4'd7:    txt = "STOPPING  ";
            4'd8:    txt = "CLOSING   ";
            4'd9:    txt = "WAIT      ";
            4'd10:   txt = "FAULT     ";
            default: txt = "UNKNOWN   ";
        endcase
        return txt;
    endfunction

    // Text width in columns: five per character
    function automatic logic [WidthBits-1:0] label_width(input logic [StateBits-1:0] st);
        logic [WidthBits-1:0] w;
        unique case (st)
            4'd1, 4'd9:        w = 6'd20;
            4'd2:              w = 6'd50;
            4'd3, 4'd10:       w = 6'd25;
            4'd4, 4'd7:        w = 6'd40;
            default:           w = 6'd35;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/scrolling_status_text_marquee.sv */
// Top level of the scrolling status text marquee for an 8x12 LED panel.
//
// Input channel s_*: one tick item per handshake, holding a millisecond
// timestamp and a pump state. Output channel m_*: one 8x12 frame item,
// eight 12-bit rows, bit 11 of each row is the leftmost column.
// Configuration: cfg_we writes cfg_data to register cfg_index on the
// rising edge (0 display enable, 1 scroll interval, 2 blink interval).
//
// Throughput: one tick item per cycle while the frame register is free or
// being taken. A tick passes an input register, one pass of compare, state
// update and 12-column glyph lookup, and lands in the frame register, which
// drives m_tvalid. Ticks that cause no frame are absorbed without output.
// When the receiver stalls, the frame register holds and the input
// register takes one more tick; s_tready drops only when both are full.
//
// Reset clears both registers' valid flags, disables the display and
// loads the default intervals; the scroll restarts off the right edge.
`default_nettype none

module scrolling_status_text_marquee
    import stm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIndexBits-1:0] cfg_index,
    input  wire logic [IntervalBits-1:0] cfg_data,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [8*InBytes-1:0]    s_tdata,  // now_ms[31:0], pump_state[35:32], zero pad
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OutBits-1:0]           m_tdata   // row_0 .. row_7, 12 bits each from bit 0
);

    logic                    enabled_reg,   enabled_next;
    logic [IntervalBits-1:0] scroll_iv_reg, scroll_iv_next;
    logic [IntervalBits-1:0] blink_iv_reg,  blink_iv_next;

    logic [StateBits-1:0]    last_state_reg, last_state_next;
    offset_t                 scroll_reg,     scroll_next;
    logic [NowBits-1:0]      last_time_reg,  last_time_next;
    logic                    phase_reg,      phase_next;

    logic                    in_valid_reg,   in_valid_next;
    logic [NowBits-1:0]      in_now_reg;
    logic [StateBits-1:0]    in_state_reg;
    logic                    out_valid_reg,  out_valid_next;
    glyph_rows_t             out_rows_reg;

    logic                    adv;
    logic                    changed;
    logic                    faulted;
    logic                    due;
    logic                    fire;
    logic [IntervalBits-1:0] interval;
    logic [NowBits-1:0]      elapsed;
    offset_t                 scroll_inc;
    offset_t                 draw_offset;
    glyph_rows_t             drawn;
    glyph_rows_t             frame;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign changed  = in_state_reg != last_state_reg;
    assign faulted  = in_state_reg == FaultState;
    assign interval = faulted ? blink_iv_reg : scroll_iv_reg;
    assign elapsed  = in_now_reg - last_time_reg;
    assign due      = elapsed >= NowBits'(interval);
    assign fire     = enabled_reg && !changed && due;

    assign scroll_inc  = scroll_reg + offset_t'(1);
    assign draw_offset = faulted ? '0 : scroll_reg;

    stm_render u_render (
        .pump_state (in_state_reg),
        .offset     (draw_offset),
        .rows       (drawn)
    );

    // Fault frames alternate: blank when the phase turns to one
    assign frame = (faulted && !phase_reg) ? '0 : drawn;

    always_comb
    begin
        enabled_next = enabled_reg;
        scroll_iv_next = scroll_iv_reg;
        blink_iv_next = blink_iv_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                RegDisplayEnabled: enabled_next   = cfg_data[0];
                RegScrollInterval: scroll_iv_next = cfg_data;
                RegBlinkInterval:  blink_iv_next  = cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        last_state_next = last_state_reg;
        scroll_next     = scroll_reg;
        last_time_next  = last_time_reg;
        phase_next      = phase_reg;
        if (adv && enabled_reg)
        begin
            if (changed)
            begin
                last_state_next = in_state_reg;
                scroll_next     = ScrollStart;
                last_time_next  = in_now_reg;
                phase_next      = 1'b0;
            end
            else if (due)
            begin
                last_time_next = in_now_reg;
                if (faulted)
                    phase_next = !phase_reg;
                else if (scroll_inc >= offset_t'(label_width(in_state_reg)))
                    scroll_next = ScrollStart;
                else
                    scroll_next = scroll_inc;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = fire;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            scroll_iv_reg  <= ScrollDefault;
            blink_iv_reg   <= BlinkDefault;
            last_state_reg <= StateReset;
            scroll_reg     <= ScrollStart;
            last_time_reg  <= '0;
            phase_reg      <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            enabled_reg    <= enabled_next;
            scroll_iv_reg  <= scroll_iv_next;
            blink_iv_reg   <= blink_iv_next;
            last_state_reg <= last_state_next;
            scroll_reg     <= scroll_next;
            last_time_reg  <= last_time_next;
            phase_reg      <= phase_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_now_reg   <= s_tdata[NowBits-1:0];
            in_state_reg <= s_tdata[NowBits +: StateBits];
        end
        if (adv && fire)
            out_rows_reg <= frame;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {RowBits'(0), out_rows_reg, RowBits'(0)};

endmodule

`default_nettype wire

/* sv/stm_render.sv */
// Glyph window renderer: draws the label of a state starting at a signed column offset.
`default_nettype none

module stm_render
    import stm_pkg::*;
(
    input  wire logic [StateBits-1:0] pump_state,
    input  wire offset_t              offset,
    output glyph_rows_t               rows
);

    label_t               text;
    logic [WidthBits-1:0] width;

    assign text  = label_text(pump_state);
    assign width = label_width(pump_state);

    always_comb
    begin
        logic signed [7:0] src;
        logic [9:0]        prod;
        logic [3:0]        gi;
        logic [3:0]        gi_c;
        logic [5:0]        gc_full;
        logic [2:0]        gc;
        logic [7:0]        ch;
        logic [4:0]        fidx;
        logic              show;
        logic [GlyphRows*GlyphWidth-1:0] glyph;

        rows = '0;
        for (int col = 0; col < PanelColumns; col++)
        begin
            src     = 8'(offset) + 8'(col);
            prod    = 10'(src[5:0]) * 10'd13;
            gi      = prod[9:6];
            gi_c    = (gi > 4'(LabelChars - 1)) ? 4'd0 : gi;
            gc_full = src[5:0] - (6'(gi) * 6'd5);
            gc      = gc_full[2:0];
            ch      = text[gi_c];
            fidx    = 5'(ch - 8'h41);
            show    = !src[7] && (src[6:0] < 7'(width)) && (gc < 3'(GlyphWidth))
                      && (ch >= 8'h41) && (ch <= 8'h5A);
            glyph   = FontRom[(fidx > 5'd25) ? 5'd0 : fidx];
            for (int r = 0; r < GlyphRows; r++)
            begin
                rows[r][PanelColumns-1-col] = show &&
                    glyph[(GlyphRows-1-r)*GlyphWidth + int'(2'd3 - gc[1:0])];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/stm_checker.sv */
// Port-level checks for the status text marquee, bound to the top level.
`default_nettype none

module stm_checker
    import stm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [OutBits-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("frame dropped while stalled");

    a_border_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RowBits-1:0] == '0) && (m_tdata[OutBits-1 -: RowBits] == '0))
        else $error("border row not blank");

    a_frame_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("frame appeared without a tick two cycles earlier");

    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with free output");

endmodule

bind scrolling_status_text_marquee stm_checker u_stm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/scrolling_status_text_marquee_test.sv */
// Self-checking bench for the status text marquee: directed and random ticks against a frame model.
`timescale 1ns / 1ps

module scrolling_status_text_marquee_test;
    import stm_pkg::*;

    typedef logic [7:0][RowBits-1:0] frame_t;

    localparam logic [StateBits-1:0] PumpValveOpen = 4'd2;
    localparam logic [StateBits-1:0] PumpRunning   = 4'd6;

    localparam logic [23:0] LetterDots [26] = '{
        24'h699F99, 24'hE9E99E, 24'h788887, 24'hE9999E, 24'hF8E88F, 24'hF8E888,
        24'h78B997, 24'h99F999, 24'hE4444E, 24'h7222A4, 24'h9ACCA9, 24'h88888F,
        24'h9FF999, 24'h9DDBB9, 24'h699996, 24'hE99E88, 24'h699BA5, 24'hE99EA9,
        24'h78611E, 24'hF44444, 24'h999996, 24'h999966, 24'h999FF9, 24'h996699,
        24'h996444, 24'hF1248F
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [IntervalBits-1:0] cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [8*InBytes-1:0]    s_tdata;  // now_ms[31:0], pump_state[35:32], zero pad
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutBits-1:0]      m_tdata;  // row_0 .. row_7, 12 bits each from bit 0

    frame_t expected_frames[$];
    int     error_count    = 0;
    int     ticks_sent     = 0;
    int     frames_checked = 0;
    bit     gaps_on        = 1'b1;
    int     receiver_hold  = 0;

    // marquee model state and register copies
    logic                    show_en;
    logic [IntervalBits-1:0] scroll_ms;
    logic [IntervalBits-1:0] blink_ms;
    logic [StateBits-1:0]    shown_state;
    int                      scroll_col;
    logic [NowBits-1:0]      last_frame_ms;
    logic                    blink_dark;

    scrolling_status_text_marquee dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic string status_label(input logic [StateBits-1:0] st);
        case (st)
            4'd1:    return "IDLE";
            4'd2:    return "VALVE OPEN";
            4'd3:    return "CHOKE";
            4'd4:    return "CRANKING";
            4'd5:    return "UNCHOKE";
            4'd6:    return "RUNNING";
            4'd7:    return "STOPPING";
            4'd8:    return "CLOSING";
            4'd9:    return "WAIT";
            4'd10:   return "FAULT";
            default: return "UNKNOWN";
        endcase
    endfunction

    function automatic frame_t render_window(input logic [StateBits-1:0] st, input int offset);
        frame_t     f;
        string      txt;
        int         width;
        int         src;
        int         gc;
        logic [7:0] ch;
        f = '0;
        txt = status_label(st);
        width = txt.len() * GlyphPitch;
        for (int col = 0; col < PanelColumns; col++) begin
            src = offset + col;
            if (src >= 0 && src < width) begin
                gc = src % GlyphPitch;
                ch = txt[src / GlyphPitch];
                if (gc < GlyphWidth && ch >= "A" && ch <= "Z")
                    for (int r = 0; r < GlyphRows; r++)
                        if (LetterDots[ch - "A"][23 - 4 * r - gc])
                            f[r + 1][PanelColumns - 1 - col] = 1'b1;
            end
        end
        return f;
    endfunction

    function automatic void reset_marquee();
        show_en       = 1'b0;
        scroll_ms     = ScrollDefault;
        blink_ms      = BlinkDefault;
        shown_state   = StateReset;
        scroll_col    = -PanelColumns;
        last_frame_ms = '0;
        blink_dark    = 1'b0;
    endfunction

    function automatic bit advance_marquee(input logic [NowBits-1:0] now,
                                           input logic [StateBits-1:0] st,
                                           output frame_t f);
        logic [NowBits-1:0]      elapsed;
        logic [IntervalBits-1:0] period;
        f = '0;
        if (!show_en)
            return 1'b0;
        if (st != shown_state) begin
            shown_state   = st;
            scroll_col    = -PanelColumns;
            last_frame_ms = now;
            blink_dark    = 1'b0;
            return 1'b0;
        end
        period = (st == FaultState) ? blink_ms : scroll_ms;
        elapsed = now - last_frame_ms;
        if (elapsed < {16'd0, period})
            return 1'b0;
        last_frame_ms = now;
        if (st == FaultState) begin
            blink_dark = ~blink_dark;
            if (!blink_dark)
                f = render_window(st, 0);
        end else begin
            f = render_window(st, scroll_col);
            scroll_col++;
            if (scroll_col >= status_label(st).len() * GlyphPitch)
                scroll_col = -PanelColumns;
        end
        return 1'b1;
    endfunction

    function automatic logic [IntervalBits-1:0] pick_interval();
        case ($urandom_range(0, 4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 4));
            3:       return 16'($urandom_range(5, 200));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic send_tick(input logic [NowBits-1:0] now, input logic [StateBits-1:0] st);
        int     gap;
        frame_t f;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, st, now};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (advance_marquee(now, st, f))
            expected_frames.push_back(f);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic settle_marquee();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CfgIndexBits-1:0] idx,
                                  input logic [IntervalBits-1:0] value);
        settle_marquee();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            RegDisplayEnabled: show_en   = value[0];
            RegScrollInterval: scroll_ms = value;
            RegBlinkInterval:  blink_ms  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_display_disabled();
        send_tick(32'h0000_0000, FaultState);
        send_tick(32'hFFFF_FFFF, PumpValveOpen);
        send_tick($urandom(), 4'($urandom_range(0, 15)));
    endtask

    task automatic test_first_tick_unknown();
        write_register(RegDisplayEnabled, 16'd1);
        send_tick(32'd0, StateReset);
        send_tick(32'd89, StateReset);
        send_tick(32'd90, StateReset);
        send_tick(32'd180, StateReset);
    endtask

    task automatic test_time_wrap();
        write_register(RegScrollInterval, 16'hFFFF);
        send_tick(32'hFFFF_FFFF, PumpRunning);
        send_tick(32'h0000_FFFD, PumpRunning);
        send_tick(32'h0000_FFFE, PumpRunning);
    endtask

    task automatic test_fault_blink();
        write_register(RegBlinkInterval, 16'd1);
        send_tick(32'd100, FaultState);
        send_tick(32'd101, FaultState);
        send_tick(32'd102, FaultState);
        send_tick(32'd102, FaultState);
        send_tick(32'd103, FaultState);
        write_register(RegBlinkInterval, 16'hFFFF);
        send_tick(32'd103 + 32'd65535, FaultState);
    endtask

    task automatic test_backpressure();
        write_register(RegScrollInterval, 16'd1);
        gaps_on = 1'b0;
        send_tick(32'd1000, PumpValveOpen);
        receiver_hold = 60;
        for (int i = 1; i <= 24; i++)
            send_tick(32'd1000 + i, PumpValveOpen);
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        logic [NowBits-1:0] now;
        write_register(RegScrollInterval, 16'd3);
        now = 32'd5000;
        send_tick(now, PumpRunning);
        repeat (4) begin
            repeat (6) begin
                now += 32'd3;
                send_tick(now, PumpRunning);
            end
            settle_marquee();
        end
    endtask

    task automatic test_random_sequences(input int budget);
        int                      counted;
        int                      quota;
        int                      run_len;
        int                      pick;
        logic [NowBits-1:0]      now;
        logic [StateBits-1:0]    st;
        logic [IntervalBits-1:0] period;
        counted = 0;
        while (counted < budget) begin
            write_register(RegScrollInterval, pick_interval());
            write_register(RegBlinkInterval, pick_interval());
            gaps_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 5) == 0) begin
                write_register(RegDisplayEnabled, 16'd0);
                repeat (8) send_tick($urandom(), 4'($urandom_range(0, 15)));
                write_register(RegDisplayEnabled, 16'd1);
            end
            quota = (counted + 80 < budget) ? counted + 80 : budget;
            while (counted < quota) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick($urandom(), 4'($urandom_range(0, 15)));
                    counted++;
                end else begin
                    st = ($urandom_range(0, 3) == 0) ? FaultState : 4'($urandom_range(0, 15));
                    now = $urandom();
                    run_len = $urandom_range(4, 70);
                    for (int i = 0; i < run_len && counted < quota; i++) begin
                        period = (st == FaultState) ? blink_ms : scroll_ms;
                        send_tick(now, st);
                        counted++;
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            st = 4'($urandom_range(0, 15));
                        else if (pick == 1)
                            now += $urandom();
                        else if (pick == 2)
                            now += 32'd0;
                        else if (pick == 3 && period > 1)
                            now += 32'(period) - 32'd1;
                        else
                            now += 32'(period) + 32'($urandom_range(0, 2));
                    end
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : frame_sink
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (receiver_hold > 0) begin
                gap = receiver_hold;
                receiver_hold = 0;
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            gap = gaps_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && receiver_hold == 0) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin : frame_checker
        frame_t want;
        frame_t got;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_frames.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected frame, expected none actual %h", $time, got);
                end else begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    for (int r = 0; r < 8; r++)
                        if (want[r] !== got[r]) begin
                            error_count++;
                            $display("%0t: row_%0d expected %h actual %h",
                                     $time, r, want[r], got[r]);
                        end
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = RegDisplayEnabled;
        cfg_data  = '0;
        reset_marquee();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_display_disabled();
        test_first_tick_unknown();
        test_time_wrap();
        test_fault_blink();
        test_backpressure();
        test_drain_pause();
        test_random_sequences(320);

        settle_marquee();
        repeat (8) @(negedge clk);
        if (expected_frames.size() != 0) begin
            error_count++;
            $display("%0t: frames still pending, expected %0d actual 0",
                     $time, expected_frames.size());
        end
        $display("Ran %0d ticks and checked %0d frames: all pump states, fault blink, scroll wrap,",
                 ticks_sent, frames_checked);
        $display("timestamp wrap, display off, intervals 1 to 65535, long output stall.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
